@@ rtl/ctt_pkg.sv @@
// Shared constants, codes and control types of the countdown timer table.
package ctt_pkg;

  localparam int unsigned CTT_CAPACITY = 16;
  localparam int unsigned CTT_AW = (CTT_CAPACITY > 1) ? $clog2(CTT_CAPACITY) : 1;
  localparam int unsigned CTT_CW = $clog2(CTT_CAPACITY + 1);
  localparam int unsigned CTT_SEC_W = 16;
  localparam int unsigned CTT_TAG_W = 32;
  localparam int unsigned CTT_REM_W = 17;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [CTT_REM_W-1:0] remaining;
    logic [CTT_TAG_W-1:0] tag;
  } entry_t;

  localparam int unsigned CTT_ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic add_push;
    logic scan_start;
    logic read_first;
    logic scan_step;
    logic flush_push;
  } ctt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_tick;
    logic live_zero;
    logic expired;
    logic pend_valid;
    logic last_entry;
  } ctt_sts_t;

endpackage

@@ rtl/ctt_in_if.sv @@
// Input channel: timer add or tick transaction.
interface ctt_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [ctt_pkg::CTT_SEC_W-1:0]  seconds;
  logic [ctt_pkg::CTT_TAG_W-1:0]  tag;

  modport source (output valid, action, seconds, tag, input ready);
  modport sink   (input valid, action, seconds, tag, output ready);
endinterface

@@ rtl/ctt_out_if.sv @@
// Output channel: one result transaction.
interface ctt_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [ctt_pkg::CTT_TAG_W-1:0]  expired_tag;
  logic                           last;

  modport source (output valid, kind, expired_tag, last, input ready);
  modport sink   (input valid, kind, expired_tag, last, output ready);
endinterface

@@ rtl/ctt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ctt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ctt_ctrl.sv @@
// Sequencer of the timer table: add, table scan and final result.
module ctt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctt_pkg::ctt_sts_t sts_i,
  output ctt_pkg::ctt_cmd_t cmd_o
);
  import ctt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.is_tick) begin
            cmd_o.scan_start = 1'b1;
            if (sts_i.live_zero) begin
              state_d = ST_FLUSH;
            end else begin
              cmd_o.read_first = 1'b1;
              state_d          = ST_SCAN;
            end
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (sts_i.out_free) begin
          cmd_o.add_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // stall only when an older expiry must leave first
        if (!(sts_i.expired && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.last_entry) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush_push = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/ctt_dp.sv @@
// Timer table datapath: entry RAM, scan pointers, pending expiry and result register.
module ctt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctt_pkg::ctt_cmd_t             cmd_i,
  output ctt_pkg::ctt_sts_t             sts_o,
  input  logic                          in_action_i,
  input  logic [ctt_pkg::CTT_SEC_W-1:0] in_seconds_i,
  input  logic [ctt_pkg::CTT_TAG_W-1:0] in_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [ctt_pkg::CTT_TAG_W-1:0] out_tag_o,
  output logic                          out_last_o
);
  import ctt_pkg::*;

  logic [CTT_SEC_W-1:0] sec_q;
  logic [CTT_TAG_W-1:0] tag_q;
  logic [CTT_CW-1:0]    live_q, live_d;
  logic [CTT_AW-1:0]    rd_q, rd_d;
  logic [CTT_CW-1:0]    wr_q, wr_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [CTT_TAG_W-1:0] pend_tag_q, pend_tag_d;
  logic                 out_valid_q, out_valid_d;
  kind_e                out_kind_q, out_kind_d;
  logic [CTT_TAG_W-1:0] out_tag_q, out_tag_d;
  logic                 out_last_q, out_last_d;

  logic                 ram_we;
  logic [CTT_AW-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [CTT_AW-1:0]    ram_raddr;
  logic [CTT_ENTRY_W-1:0] ram_rdata;
  entry_t               cur;

  logic out_free, full, expired, last_entry, push;

  ctt_ram #(
    .Width (CTT_ENTRY_W),
    .Depth (CTT_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur        = entry_t'(ram_rdata);
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (live_q == CTT_CW'(CTT_CAPACITY));
  assign expired    = (cur.remaining <= CTT_REM_W'(1));
  assign last_entry = ((CTT_CW'(rd_q) + CTT_CW'(1)) == live_q);

  assign sts_o.out_free   = out_free;
  assign sts_o.is_tick    = (action_e'(in_action_i) == ACT_TICK);
  assign sts_o.live_zero  = (live_q == '0);
  assign sts_o.expired    = expired;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.last_entry = last_entry;

  always_comb begin
    ram_re    = cmd_i.read_first || (cmd_i.scan_step && !last_entry);
    ram_raddr = cmd_i.read_first ? '0 : rd_q + CTT_AW'(1);
    ram_we    = 1'b0;
    ram_waddr = wr_q[CTT_AW-1:0];
    ram_wdata = '{remaining: cur.remaining - CTT_REM_W'(1), tag: cur.tag};
    if (cmd_i.add_push && !full) begin
      ram_we    = 1'b1;
      ram_waddr = live_q[CTT_AW-1:0];
      ram_wdata = '{remaining: CTT_REM_W'(sec_q), tag: tag_q};
    end else if (cmd_i.scan_step && !expired) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    live_d       = live_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    pend_valid_d = pend_valid_q;
    pend_tag_d   = pend_tag_q;
    out_kind_d   = out_kind_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;
    push         = 1'b0;

    if (cmd_i.scan_start) begin
      rd_d         = '0;
      wr_d         = '0;
      pend_valid_d = 1'b0;
    end

    if (cmd_i.add_push) begin
      push       = 1'b1;
      out_kind_d = full ? KIND_ADD_FULL : KIND_ADD_OK;
      out_tag_d  = '0;
      out_last_d = 1'b1;
      if (!full) begin
        live_d = live_q + CTT_CW'(1);
      end
    end

    if (cmd_i.scan_step) begin
      rd_d = rd_q + CTT_AW'(1);
      if (expired) begin
        if (pend_valid_q) begin
          push       = 1'b1;
          out_kind_d = KIND_EXPIRED;
          out_tag_d  = pend_tag_q;
          out_last_d = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_tag_d   = cur.tag;
      end else begin
        wr_d = wr_q + CTT_CW'(1);
      end
    end

    if (cmd_i.flush_push) begin
      push         = 1'b1;
      out_kind_d   = pend_valid_q ? KIND_EXPIRED : KIND_NONE;
      out_tag_d    = pend_valid_q ? pend_tag_q : '0;
      out_last_d   = 1'b1;
      live_d       = wr_q;
      pend_valid_d = 1'b0;
    end

    out_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      live_q       <= live_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sec_q <= in_seconds_i;
      tag_q <= in_tag_i;
    end
    pend_tag_q <= pend_tag_d;
    out_kind_q <= out_kind_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CTT_CW'(CTT_CAPACITY))
    else $error("live count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> wr_q <= CTT_CW'(rd_q))
    else $error("write pointer passed read pointer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result register overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_NONE || out_kind_q == KIND_ADD_OK ||
                    out_kind_q == KIND_ADD_FULL) |-> out_last_q && out_tag_q == '0)
    else $error("single result without last marker or with tag");

endmodule

@@ rtl/countdown_timer_table_core.sv @@
// Countdown timer table top level: sequencer plus datapath.
// A transaction is taken only while the block is idle. An add leaves one
// result. In a tick the entries are walked one per cycle through the single
// read port of the entry RAM, unless an older expiry waits on a busy sink;
// survivors are written back compacted, and expired tags leave in table
// order.
module countdown_timer_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctt_in_if.sink     in_i,
  ctt_out_if.source  out_o
);
  import ctt_pkg::*;

  ctt_cmd_t cmd;
  ctt_sts_t sts;

  ctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_action_i  (in_i.action),
    .in_seconds_i (in_i.seconds),
    .in_tag_i     (in_i.tag),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_kind_o   (out_o.kind),
    .out_tag_o    (out_o.expired_tag),
    .out_last_o   (out_o.last)
  );

endmodule

@@ tb/tb_countdown_timer_table_core.sv @@
`timescale 1ns / 100ps
// Testbench for countdown_timer_table_core: directed and random adds and ticks.

import ctt_pkg::*;

class timer_table_tracker;
  typedef struct {
    kind_e                kind;
    logic [CTT_TAG_W-1:0] tag;
    logic                 last;
  } timer_result_t;

  logic [CTT_REM_W-1:0] ticks_left [CTT_CAPACITY];
  logic [CTT_TAG_W-1:0] slot_tag [CTT_CAPACITY];
  int unsigned          live_slots;
  timer_result_t        due_results [$];
  int unsigned          mismatches;

  function new();
    live_slots = 0;
    mismatches = 0;
  endfunction

  function void apply_request(logic act, logic [CTT_SEC_W-1:0] secs,
                              logic [CTT_TAG_W-1:0] tg);
    timer_result_t        res;
    logic [CTT_TAG_W-1:0] fired_tags [$];
    int unsigned          kept;
    kept     = 0;
    res.tag  = '0;
    res.last = 1'b1;
    if (act == ACT_ADD) begin
      if (live_slots >= CTT_CAPACITY) begin
        res.kind = KIND_ADD_FULL;
      end else begin
        ticks_left[live_slots] = {1'b0, secs};
        slot_tag[live_slots]   = tg;
        live_slots++;
        res.kind = KIND_ADD_OK;
      end
      due_results.push_back(res);
    end else begin
      for (int unsigned i = 0; i < live_slots; i++) begin
        if (ticks_left[i] <= 1) begin
          fired_tags.push_back(slot_tag[i]);
        end else begin
          ticks_left[kept] = ticks_left[i] - 1'b1;
          slot_tag[kept]   = slot_tag[i];
          kept++;
        end
      end
      live_slots = kept;
      if (fired_tags.size() == 0) begin
        res.kind = KIND_NONE;
        due_results.push_back(res);
      end else begin
        foreach (fired_tags[j]) begin
          res.kind = KIND_EXPIRED;
          res.tag  = fired_tags[j];
          res.last = (j == fired_tags.size() - 1);
          due_results.push_back(res);
        end
      end
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [CTT_TAG_W-1:0] tg, logic last);
    timer_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result kind %0d tag %h last %b", $time, kind, tg, last);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (kind !== want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
      mismatches++;
    end
    if (tg !== want.tag) begin
      $display("%0t: expired_tag expected %h actual %h", $time, want.tag, tg);
      mismatches++;
    end
    if (last !== want.last) begin
      $display("%0t: last expected %b actual %b", $time, want.last, last);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return due_results.size();
  endfunction
endclass

module tb_countdown_timer_table_core;
  logic               clk_i = 1'b0;
  logic               rst_ni;
  int unsigned        send_gap_pct;
  int unsigned        recv_gap_pct;
  int unsigned        hold_request;
  timer_table_tracker timers;

  ctt_in_if  in_ch ();
  ctt_out_if out_ch ();

  countdown_timer_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_item(input logic act, input logic [CTT_SEC_W-1:0] secs,
                           input logic [CTT_TAG_W-1:0] tg);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.seconds <= secs;
    in_ch.tag     <= tg;
    do @(posedge clk_i); while (!in_ch.ready);
    timers.apply_request(act, secs, tg);
  endtask

  task automatic send_random_item();
    logic [CTT_SEC_W-1:0] secs;
    int unsigned          pick;
    logic                 act;
    pick = $urandom_range(0, 99);
    if (pick == 0) begin
      secs = CTT_SEC_W'($urandom);
    end else if (pick < 30) begin
      secs = CTT_SEC_W'($urandom_range(5, 40));
    end else begin
      secs = CTT_SEC_W'($urandom_range(0, 4));
    end
    act = ($urandom_range(0, 99) < 40) ? ACT_TICK : ACT_ADD;
    send_item(act, secs, $urandom);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (timers.outstanding() != 0);
  endtask

  initial begin
    timers        = new();
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_ADD;
    in_ch.seconds = '0;
    in_ch.tag     = '0;
    send_gap_pct  = 8;
    recv_gap_pct  = 67;
    hold_request  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_TICK, 16'hffff, 32'hffff_ffff);
    send_item(ACT_ADD, 16'd0, 32'h0000_0000);
    send_item(ACT_ADD, 16'd1, 32'hffff_ffff);
    send_item(ACT_ADD, 16'd2, 32'ha5a5_a5a5);
    send_item(ACT_TICK, 16'd0, 32'h0);
    repeat (CTT_CAPACITY - 1) send_item(ACT_ADD, 16'd1, $urandom);
    send_item(ACT_ADD, 16'd3, 32'h1234_5678);
    send_item(ACT_TICK, 16'h5555, 32'haaaa_aaaa);
    send_item(ACT_ADD, 16'hffff, 32'h5a5a_5a5a);
    send_item(ACT_TICK, 16'h0, 32'h0);

    repeat (150) send_random_item();
    wait_for_results();

    send_gap_pct = 67;
    recv_gap_pct = 8;
    repeat (150) send_random_item();
    wait_for_results();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_request = 300;
    repeat (100) send_random_item();
    wait_for_results();

    repeat (40) @(posedge clk_i);
    if (timers.mismatches == 0 && timers.outstanding() == 0) begin
      $display("countdown_timer_table_core verification clean");
    end else begin
      $display("%0t: %0d results still expected", $time, timers.outstanding());
      $display("countdown_timer_table_core verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        timers.check_result(out_ch.kind, out_ch.expired_tag, out_ch.last);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("countdown_timer_table_core verification failed");
    $finish;
  end
endmodule
